// ----- hdl/epc_pkg.sv -----
package epc_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_UNLINK = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  // hash mix constants
  localparam int          HASH_W = 32;
  localparam logic [31:0] MIX_C1 = 32'h9E3779B9;
  localparam logic [31:0] MIX_C2 = 32'h85EBCA6B;
  localparam logic [31:0] MIX_C3 = 32'hC2B2AE35;
  localparam int          MIX_S1 = 16;
  localparam int          MIX_S2 = 13;

  // one command as it travels from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] rid;
    logic [31:0] own;
    logic [31:0] key;
    logic [31:0] glo;
    logic [31:0] ghi;
    logic [31:0] fval;
  } work_t;

  // one result transaction
  typedef struct packed {
    logic        hit;
    logic        bypass;
    logic [31:0] value;
  } res_t;

  // one cache entry word
  typedef struct packed {
    logic        valid;
    logic [31:0] stamp;
    logic [31:0] own;
    logic [31:0] key;
    logic [31:0] glo;
    logic [31:0] ghi;
    logic [31:0] result;
  } entry_t;

endpackage

// ----- hdl/epc_ram.sv -----
module epc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/epc_fifo.sv -----
module epc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/epc_front.sv -----
module epc_front #(
  parameter int CACHE_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  epc_pkg::work_t       in_item,
  output logic                 busy,
  output logic                 q_push,
  input  logic                 q_full,
  output epc_pkg::work_t       q_item,
  output logic [$clog2(CACHE_ENTRIES)-1:0] q_idx
);

  import epc_pkg::*;

  localparam int          IW      = $clog2(CACHE_ENTRIES);
  localparam int          KSH     = 31 + IW;
  localparam logic [IW:0] DIVISOR = (IW + 1)'(CACHE_ENTRIES);
  // floor(2**KSH / CACHE_ENTRIES) fits in 32 bits and underestimates the
  // quotient by at most one, so one compare and subtract finishes the remainder
  localparam logic [31:0] RECIP   = 32'((64'd1 << KSH) / 64'(CACHE_ENTRIES));

  typedef enum logic [3:0] {
    F_IDLE, F_MUL1, F_MUL2, F_MIX, F_FIN, F_RCP, F_QUO, F_SUB, F_RED, F_PUSH
  } fstate_t;

  fstate_t             state;
  work_t               item;
  logic [31:0]         prod;
  logic [31:0]         h;
  logic [IW-1:0]       rem;
  logic [31:0]         mixed;
  logic [2*HASH_W-1:0] wide;
  logic [31:0]         quot;
  logic [31:0]         qn;
  logic [IW:0]         diff;

  assign busy   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_item = item;
  assign q_idx  = rem;

  // mix shift and estimated quotient
  assign mixed = h ^ (h >> MIX_S1);
  assign quot  = 32'(wide >> KSH);

  // hash and index sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            state <= F_MUL1;
          end
        end
        F_MUL1: begin
          prod  <= item.glo * MIX_C1;
          state <= F_MUL2;
        end
        F_MUL2: begin
          h     <= item.key ^ prod ^ (item.ghi * MIX_C2);
          state <= F_MIX;
        end
        F_MIX: begin
          h     <= mixed * MIX_C3;
          state <= F_FIN;
        end
        F_FIN: begin
          h     <= h ^ (h >> MIX_S2);
          state <= F_RCP;
        end
        F_RCP: begin
          wide  <= (2 * HASH_W)'(h) * (2 * HASH_W)'(RECIP);
          state <= F_QUO;
        end
        F_QUO: begin
          qn    <= quot * 32'(CACHE_ENTRIES);
          state <= F_SUB;
        end
        F_SUB: begin
          diff  <= (IW + 1)'(h - qn);
          state <= F_RED;
        end
        F_RED: begin
          if (diff >= DIVISOR) begin
            rem <= IW'(diff - DIVISOR);
          end else begin
            rem <= diff[IW-1:0];
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/epc_back.sv -----
module epc_back #(
  parameter int THREAD_SLOTS  = 32,
  parameter int CACHE_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 inv_en,
  output logic                 clearing,
  input  logic                 q_empty,
  input  epc_pkg::work_t       q_item,
  input  logic [$clog2(CACHE_ENTRIES)-1:0] q_idx,
  output logic                 q_pop,
  input  logic                 o_full,
  output logic                 o_push,
  output epc_pkg::res_t        o_data
);

  import epc_pkg::*;

  localparam int IW     = $clog2(CACHE_ENTRIES);
  localparam int SW     = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CW     = $clog2(THREAD_SLOTS + 1);
  localparam int EDEPTH = THREAD_SLOTS * (2 ** IW);
  localparam int AW     = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int EW     = $bits(entry_t);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_SRCH_RD, B_SRCH_CMP, B_CLAIM,
    B_ENT_RD, B_ENT_CMP, B_OUT, B_UNL_RD, B_UNL_CMP
  } bstate_t;

  bstate_t       state;
  logic [31:0]   epoch;
  logic [CW-1:0] cnt;
  logic [SW-1:0] ptr;
  logic [SW-1:0] slot;
  logic [AW-1:0] clr;
  res_t          res;

  logic          s_we;
  logic [SW-1:0] s_waddr;
  logic [SW-1:0] s_raddr;
  logic [31:0]   s_rdata;
  logic          e_we;
  logic [AW-1:0] e_waddr;
  logic [AW-1:0] e_raddr;
  entry_t        e_wdata;
  logic [EW-1:0] e_rbits;
  entry_t        e_rdata;
  logic          key_match;
  logic          hit_now;

  assign clearing = (state == B_CLEAR);
  assign o_data   = res;
  assign o_push   = (state == B_OUT) && !o_full;
  assign e_rdata  = entry_t'(e_rbits);

  // comparisons on the entry just read
  assign key_match = (e_rdata.key == q_item.key) && (e_rdata.glo == q_item.glo) &&
                     (e_rdata.ghi == q_item.ghi);
  assign hit_now   = e_rdata.valid && (e_rdata.stamp == epoch) &&
                     (e_rdata.own == q_item.own) && key_match;

  // slot owner table
  epc_ram #(.WIDTH(32), .DEPTH(THREAD_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (q_item.rid),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // entry store, one row of entries per slot
  epc_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rbits)
  );

  // memory port control
  always_comb begin
    s_we    = 1'b0;
    s_waddr = cnt[SW-1:0];
    s_raddr = ptr;
    e_we    = 1'b0;
    e_waddr = AW'({slot, q_idx});
    e_raddr = AW'({slot, q_idx});
    e_wdata = e_rdata;
    q_pop   = 1'b0;
    case (state)
      B_CLEAR: begin
        e_we          = 1'b1;
        e_waddr       = clr;
        e_wdata.valid = 1'b0;
      end
      B_IDLE: begin
        if (!q_empty) begin
          if (q_item.cmd == CMD_TICK) begin
            q_pop = 1'b1;
          end else if (q_item.cmd == CMD_UNLINK && !inv_en) begin
            q_pop = 1'b1;
          end
        end
      end
      B_CLAIM: begin
        s_we = (cnt != CW'(THREAD_SLOTS));
      end
      B_ENT_RD: begin
        if (q_item.cmd == CMD_FILL) begin
          e_we           = 1'b1;
          e_wdata.valid  = 1'b1;
          e_wdata.stamp  = epoch;
          e_wdata.own    = q_item.own;
          e_wdata.key    = q_item.key;
          e_wdata.glo    = q_item.glo;
          e_wdata.ghi    = q_item.ghi;
          e_wdata.result = q_item.fval;
        end
      end
      B_OUT: begin
        q_pop = !o_full;
      end
      B_UNL_RD: begin
        e_raddr = AW'({ptr, q_idx});
      end
      B_UNL_CMP: begin
        e_we          = e_rdata.valid && key_match;
        e_waddr       = AW'({ptr, q_idx});
        e_wdata.valid = 1'b0;
        q_pop         = (ptr == SW'(THREAD_SLOTS - 1));
      end
      default: begin
      end
    endcase
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      epoch <= '0;
      cnt   <= '0;
      clr   <= '0;
      ptr   <= '0;
      slot  <= '0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(EDEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            ptr <= '0;
            case (q_item.cmd)
              CMD_TICK: begin
                epoch <= epoch + 1'b1;
              end
              CMD_UNLINK: begin
                if (inv_en) begin
                  state <= B_UNL_RD;
                end
              end
              default: begin
                if (q_item.own == '0 || q_item.rid == '0) begin
                  res   <= '{hit: 1'b0, bypass: 1'b1, value: '0};
                  state <= B_OUT;
                end else if (cnt == '0) begin
                  state <= B_CLAIM;
                end else begin
                  state <= B_SRCH_RD;
                end
              end
            endcase
          end
        end
        B_SRCH_RD: begin
          state <= B_SRCH_CMP;
        end
        B_SRCH_CMP: begin
          if (s_rdata == q_item.rid) begin
            slot  <= ptr;
            state <= B_ENT_RD;
          end else if (CW'(ptr) + 1'b1 == cnt) begin
            state <= B_CLAIM;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= B_SRCH_RD;
          end
        end
        B_CLAIM: begin
          if (cnt == CW'(THREAD_SLOTS)) begin
            res   <= '{hit: 1'b0, bypass: 1'b1, value: '0};
            state <= B_OUT;
          end else begin
            slot  <= cnt[SW-1:0];
            cnt   <= cnt + 1'b1;
            state <= B_ENT_RD;
          end
        end
        B_ENT_RD: begin
          if (q_item.cmd == CMD_FILL) begin
            res   <= '{hit: 1'b0, bypass: 1'b0, value: '0};
            state <= B_OUT;
          end else begin
            state <= B_ENT_CMP;
          end
        end
        B_ENT_CMP: begin
          res.hit    <= hit_now;
          res.bypass <= 1'b0;
          res.value  <= hit_now ? e_rdata.result : '0;
          state      <= B_OUT;
        end
        B_OUT: begin
          if (!o_full) begin
            state <= B_IDLE;
          end
        end
        B_UNL_RD: begin
          state <= B_UNL_CMP;
        end
        B_UNL_CMP: begin
          if (ptr == SW'(THREAD_SLOTS - 1)) begin
            state <= B_IDLE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= B_UNL_RD;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/epoch_direct_mapped_lookup_cache_top.sv -----
// Direct-mapped lookup cache with one row of entries per requester slot.
// Input channel: push/full. An item is taken when push is high and full low.
// Results: empty/pop. Lookups and fills each give one result transaction;
// unlink and tick commands give none. The oldest result stays on hit, bypass
// and cached_value while empty is low and leaves when pop is taken.
// Configuration: cfg_we writes cfg_wdata into invalidate_enable at once.
// The front runs the hash multiplies and the reciprocal index reduction,
// then the back dispatches, walks the slot table reading and comparing
// each slot visited, accesses the entry and gives the result. An unlink
// walks all slots, reading and comparing each. The front takes a new item
// only once its sequence is done, and the back handles one command at a
// time through the single slot-table read port; front and back
// overlap through a two-entry command queue.
// Reset: the back sweeps all THREAD_SLOTS * 2**clog2(CACHE_ENTRIES) entry
// words clearing valid bits, one entry a cycle, with full held high.
// A stalled result side fills the two-entry result queue and then holds the
// back, which in turn backs up the command queue and raises full.
module epoch_direct_mapped_lookup_cache_top #(
  parameter int THREAD_SLOTS  = 32,
  parameter int CACHE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [31:0] requester_id,
  input  logic [31:0] owner,
  input  logic [31:0] hash_key,
  input  logic [31:0] guid_low,
  input  logic [31:0] guid_high,
  input  logic [31:0] fill_value,
  output logic        empty,
  input  logic        pop,
  output logic        hit,
  output logic        bypass,
  output logic [31:0] cached_value,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  import epc_pkg::*;

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int QW = $bits(work_t) + IW;

  logic          inv_en;
  logic          clearing;
  logic          front_busy;
  work_t         in_item;
  work_t         f_item;
  logic [IW-1:0] f_idx;
  logic          f_push;
  logic          cq_full;
  logic          cq_empty;
  logic          cq_pop;
  logic [QW-1:0] cq_rdata;
  work_t         b_item;
  logic [IW-1:0] b_idx;
  logic          rq_full;
  logic          rq_push;
  res_t          b_res;
  res_t          rq_rdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_en <= 1'b0;
    end else if (cfg_we) begin
      inv_en <= cfg_wdata;
    end
  end

  assign in_item = '{cmd: cmd_t'(command), rid: requester_id, own: owner, key: hash_key,
                     glo: guid_low, ghi: guid_high, fval: fill_value};
  assign full    = front_busy || clearing;

  // hash front end
  epc_front #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push && !full),
    .in_item  (in_item),
    .busy     (front_busy),
    .q_push   (f_push),
    .q_full   (cq_full),
    .q_item   (f_item),
    .q_idx    (f_idx)
  );

  // command queue between front and back
  epc_fifo #(.WIDTH(QW), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_item, f_idx}),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  assign b_item = work_t'(cq_rdata[QW-1:IW]);
  assign b_idx  = cq_rdata[IW-1:0];

  // slot search and entry access
  epc_back #(.THREAD_SLOTS(THREAD_SLOTS), .CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .inv_en   (inv_en),
    .clearing (clearing),
    .q_empty  (cq_empty),
    .q_item   (b_item),
    .q_idx    (b_idx),
    .q_pop    (cq_pop),
    .o_full   (rq_full),
    .o_push   (rq_push),
    .o_data   (b_res)
  );

  // result queue
  epc_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (b_res),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign hit          = rq_rdata.hit;
  assign bypass       = rq_rdata.bypass;
  assign cached_value = rq_rdata.value;

  // reset starts the clearing sweep, which holds off input
  a_reset_blocks: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  // a result is never both a hit and a bypass
  a_hit_bypass: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(hit && bypass))
    else $error("hit and bypass together");

  // only a hit carries a value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hit) |-> (cached_value == '0))
    else $error("nonzero value without hit");

  // back never pushes a result into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rq_push |-> !rq_full)
    else $error("result queue overflow");

endmodule

// ----- verif/epc_cache_checker.sv -----
module epc_cache_checker
  import epc_pkg::*;
#(
  parameter int THREAD_SLOTS  = 32,
  parameter int CACHE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  command,
  input  logic [31:0] requester_id,
  input  logic [31:0] owner,
  input  logic [31:0] hash_key,
  input  logic [31:0] guid_low,
  input  logic [31:0] guid_high,
  input  logic [31:0] fill_value,
  input  logic        empty,
  input  logic        pop,
  input  logic        hit,
  input  logic        bypass,
  input  logic [31:0] cached_value,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int          errors,
  output int          pending
);

  // shadow copy of the cache state
  logic [31:0] slot_rid [THREAD_SLOTS];
  logic [31:0] epoch;
  logic        inval_on;
  entry_t      ent [THREAD_SLOTS][CACHE_ENTRIES];
  res_t        expected_results[$];

  function automatic int entry_index(logic [31:0] key, logic [31:0] lo, logic [31:0] hi);
    logic [31:0] h;
    h = key ^ (lo * MIX_C1) ^ (hi * MIX_C2);
    h = h ^ (h >> MIX_S1);
    h = h * MIX_C3;
    h = h ^ (h >> MIX_S2);
    return int'(h % CACHE_ENTRIES);
  endfunction

  // owned slot wins, else claim the lowest free one and invalidate its row
  function automatic int claim_slot(logic [31:0] rid);
    if (rid == 0) return -1;
    for (int i = 0; i < THREAD_SLOTS; i++)
      if (slot_rid[i] == rid) return i;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (slot_rid[i] == 0) begin
        slot_rid[i] = rid;
        for (int e = 0; e < CACHE_ENTRIES; e++) ent[i][e].valid = 1'b0;
        return i;
      end
    end
    return -1;
  endfunction

  // apply one accepted transaction and queue its result, if any
  function automatic void predict_cache(cmd_t cmd, logic [31:0] rid, logic [31:0] own,
      logic [31:0] key, logic [31:0] lo, logic [31:0] hi, logic [31:0] fval);
    int   idx;
    int   s;
    res_t r;
    idx = entry_index(key, lo, hi);
    r   = '0;
    case (cmd)
      CMD_TICK: begin
        epoch = epoch + 1;
        return;
      end
      CMD_UNLINK: begin
        if (inval_on)
          for (int i = 0; i < THREAD_SLOTS; i++)
            if (ent[i][idx].key == key && ent[i][idx].glo == lo && ent[i][idx].ghi == hi)
              ent[i][idx].valid = 1'b0;
        return;
      end
      default: ;
    endcase
    s = (own == 0) ? -1 : claim_slot(rid);
    if (s < 0) begin
      r.bypass = 1'b1;
    end else if (cmd == CMD_LOOKUP) begin
      if (ent[s][idx].valid && ent[s][idx].stamp == epoch && ent[s][idx].own == own &&
          ent[s][idx].key == key && ent[s][idx].glo == lo && ent[s][idx].ghi == hi) begin
        r.hit   = 1'b1;
        r.value = ent[s][idx].result;
      end
    end else begin
      ent[s][idx] = '{valid: 1'b1, stamp: epoch, own: own, key: key, glo: lo, ghi: hi,
                      result: fval};
    end
    expected_results.push_back(r);
  endfunction

  assign pending = expected_results.size();

  // watch the channels
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      errors = 0;
      epoch = '0;
      inval_on = 1'b0;
      expected_results.delete();
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        slot_rid[i] = '0;
        for (int j = 0; j < CACHE_ENTRIES; j++) ent[i][j] = '0;
      end
    end else begin
      if (cfg_we) inval_on = cfg_wdata;
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (hit !== e.hit) begin
            $error("hit: expected %0h actual %0h", e.hit, hit);
            errors++;
          end
          if (bypass !== e.bypass) begin
            $error("bypass: expected %0h actual %0h", e.bypass, bypass);
            errors++;
          end
          if (cached_value !== e.value) begin
            $error("cached_value: expected %0h actual %0h", e.value, cached_value);
            errors++;
          end
        end
      end
      if (push && !full)
        predict_cache(cmd_t'(command), requester_id, owner, hash_key, guid_low, guid_high,
                      fill_value);
    end
  end

endmodule

// ----- verif/tb_epoch_direct_mapped_lookup_cache_top.sv -----
module tb_epoch_direct_mapped_lookup_cache_top;
  import epc_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  command;
  logic [31:0] requester_id;
  logic [31:0] owner;
  logic [31:0] hash_key;
  logic [31:0] guid_low;
  logic [31:0] guid_high;
  logic [31:0] fill_value;
  logic        empty;
  logic        pop;
  logic        hit;
  logic        bypass;
  logic [31:0] cached_value;
  logic        cfg_we;
  logic        cfg_wdata;
  int          errors;
  int          pending;

  // shared control between stimulus and the result side
  logic        quiet;
  logic        long_stall;

  // small pools so that fills and lookups meet again
  logic [31:0] rid_pool [36];
  logic [31:0] own_pool [3];
  logic [31:0] obj_key  [8];
  logic [31:0] obj_lo   [8];
  logic [31:0] obj_hi   [8];

  epoch_direct_mapped_lookup_cache_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .requester_id(requester_id), .owner(owner), .hash_key(hash_key),
    .guid_low(guid_low), .guid_high(guid_high), .fill_value(fill_value),
    .empty(empty), .pop(pop), .hit(hit), .bypass(bypass), .cached_value(cached_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  epc_cache_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .requester_id(requester_id), .owner(owner), .hash_key(hash_key),
    .guid_low(guid_low), .guid_high(guid_high), .fill_value(fill_value),
    .empty(empty), .pop(pop), .hit(hit), .bypass(bypass), .cached_value(cached_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

  // result side: random pops, one long hold-off on request
  always @(posedge clk) begin
    static int  stall_left = 0;
    static bit  stall_taken = 0;
    if (rst) begin
      pop <= 1'b0;
    end else if (long_stall && !stall_taken) begin
      stall_taken = 1;
      stall_left = 600;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= quiet || ($urandom_range(99) >= 24);
    end
  end

  // offer one transaction and hold it until taken
  task automatic send(cmd_t cmd, logic [31:0] rid, logic [31:0] own, logic [31:0] key,
                      logic [31:0] lo, logic [31:0] hi, logic [31:0] fval);
    push         <= 1'b1;
    command      <= cmd;
    requester_id <= rid;
    owner        <= own;
    hash_key     <= key;
    guid_low     <= lo;
    guid_high    <= hi;
    fill_value   <= fval;
    do @(posedge clk); while (full);
    while (!quiet && $urandom_range(99) < 24) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drain all results, then let an unlink sweep finish
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_inval(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int          r;
    int          o;
    cmd_t        cmd;
    logic [31:0] own;
    r = $urandom_range(99);
    o = $urandom_range(7);
    if (r < 45) cmd = CMD_LOOKUP;
    else if (r < 85) cmd = CMD_FILL;
    else if (r < 96) cmd = CMD_UNLINK;
    else cmd = CMD_TICK;
    own = ($urandom_range(99) < 5) ? 32'h0 : own_pool[$urandom_range(2)];
    // noise: everything random
    if ($urandom_range(99) < 10)
      send(cmd_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
    else
      send(cmd, rid_pool[$urandom_range(35)], own, obj_key[o], obj_lo[o], obj_hi[o],
           $urandom);
  endtask

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    command      = CMD_LOOKUP;
    requester_id = '0;
    owner        = '0;
    hash_key     = '0;
    guid_low     = '0;
    guid_high    = '0;
    fill_value   = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    quiet        = 1'b0;
    long_stall   = 1'b0;
    foreach (rid_pool[i]) rid_pool[i] = $urandom | 32'h1;
    rid_pool[0] = 32'hFFFF_FFFF;
    rid_pool[1] = 32'h1;
    foreach (own_pool[i]) own_pool[i] = $urandom | 32'h1;
    own_pool[0] = 32'hFFFF_FFFF;
    foreach (obj_key[i]) begin
      obj_key[i] = $urandom;
      obj_lo[i]  = $urandom;
      obj_hi[i]  = $urandom;
    end
    obj_key[0] = '1; obj_lo[0] = '1; obj_hi[0] = '1;
    obj_key[1] = '0; obj_lo[1] = '0; obj_hi[1] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_inval(1'b0);

    // directed: bypass cases, fill and hit, owner mismatch, stale epoch, unlink
    send(CMD_LOOKUP, 32'h1, 32'h0, '1, '1, '1, '0);
    send(CMD_FILL, 32'h0, 32'h5, '1, '1, '1, '1);
    send(CMD_LOOKUP, 32'h0, 32'h5, '1, '1, '1, '0);
    send(CMD_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1, '1);
    send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1, '0);
    send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h7, '1, '1, '1, '0);
    send(CMD_FILL, 32'h1, 32'h7, '0, '0, '0, 32'h1234_5678);
    send(CMD_LOOKUP, 32'h1, 32'h7, '0, '0, '0, '0);
    send(CMD_LOOKUP, 32'h1, 32'h7, '1, '1, '1, '0);
    send(CMD_UNLINK, 32'h0, 32'h0, '0, '0, '0, '0);
    send(CMD_LOOKUP, 32'h1, 32'h7, '0, '0, '0, '0);
    send(CMD_TICK, 32'h0, 32'h0, '0, '0, '0, '0);
    send(CMD_LOOKUP, 32'h1, 32'h7, '0, '0, '0, '0);
    send(CMD_FILL, 32'h1, 32'h7, '0, '0, '0, 32'hFFFF_FFFF);
    send(CMD_FILL, 32'hFFFF_FFFF, 32'h7, '0, '0, '0, 32'h55);
    settle();
    write_inval(1'b1);
    send(CMD_UNLINK, 32'h0, 32'h0, '0, '0, '0, '0);
    send(CMD_LOOKUP, 32'h1, 32'h7, '0, '0, '0, '0);
    send(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h7, '0, '0, '0, '0);
    send(CMD_UNLINK, 32'h0, 32'h0, 32'h1, '0, '0, '0);
    settle();

    // random phases with the register flipped between them
    for (int ph = 0; ph < 4; ph++) begin
      write_inval(ph[0]);
      for (int n = 0; n < 290; n++) begin
        if (ph == 0 && n == 60) long_stall <= 1'b1;
        if (ph == 2 && n == 100) quiet <= 1'b1;
        if (ph == 2 && n == 220) quiet <= 1'b0;
        random_item();
      end
      settle();
    end

    push <= 1'b0;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
